// ===== hw/rtl/tds_pkg.sv =====
`timescale 1ns / 1ps
package tds_pkg;

  localparam int TASK_COUNT = 8;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_DELAY = 2'd1,
    CMD_SCHED = 2'd2,
    CMD_READY = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    WHERE_NONE    = 2'd0,
    WHERE_READY   = 2'd1,
    WHERE_DELAYED = 2'd2
  } where_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_REINS,
    ST_OUT
  } state_e;

  // chain control, shared by every cell
  typedef struct packed {
    logic        shift_out;  // drop the head, everyone moves one place forward
    logic        remove;     // drop the entry matching rm_id, rest close up
    logic        insert;     // sorted insert of ins_id/ins_key
    logic        append;     // append ins_id at the fill position
    logic [31:0] ins_key;
  } chain_ctl_t;

endpackage

// ===== hw/rtl/tds_if.sv =====
`timescale 1ns / 1ps
interface tds_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [2:0]  task_id;
  logic [31:0] delay_ticks;
  modport source (output valid, cmd, task_id, delay_ticks, input ready);
  modport sink (input valid, cmd, task_id, delay_ticks, output ready);
endinterface

interface tds_out_if;
  logic       valid;
  logic       ready;
  logic       must_switch;
  logic [2:0] current_task;
  logic       current_is_idle;
  logic [3:0] ready_count;
  logic [3:0] delayed_count;
  modport source (output valid, must_switch, current_task, current_is_idle, ready_count,
                  delayed_count, input ready);
  modport sink (input valid, must_switch, current_task, current_is_idle, ready_count,
                delayed_count, output ready);
endinterface

// ===== hw/rtl/tds_cell.sv =====
`timescale 1ns / 1ps
// one list slot; position index pos is fixed per cell
module tds_cell #(
  parameter int IdW = 3
) (
  input  logic                  clk_i,
  input  tds_pkg::chain_ctl_t   ctl_i,
  input  logic [IdW-1:0]        ins_id_i,
  input  logic                  here_valid_i,   // pos < fill
  input  logic                  at_fill_i,      // pos == fill
  // own contents
  output logic [IdW-1:0]        id_o,
  output logic [31:0]           key_o,
  output logic                  go_after_o,     // valid and key <= ins_key
  output logic                  match_o,
  input  logic [IdW-1:0]        rm_id_i,
  // neighbours
  input  logic [IdW-1:0]        prev_id_i,
  input  logic [31:0]           prev_key_i,
  input  logic                  prev_go_after_i,
  input  logic                  prev_shifts_i,  // a cell before me matched
  input  logic [IdW-1:0]        next_id_i,
  input  logic [31:0]           next_key_i,
  output logic                  shifts_o
);
  logic [IdW-1:0] id_q, id_d;
  logic [31:0]    key_q, key_d;

  assign id_o       = id_q;
  assign key_o      = key_q;
  assign match_o    = here_valid_i && (id_q == rm_id_i);
  assign shifts_o   = prev_shifts_i || match_o;
  assign go_after_o = here_valid_i && (key_q <= ctl_i.ins_key);

  always_comb begin
    id_d  = id_q;
    key_d = key_q;
    if (ctl_i.shift_out || (ctl_i.remove && shifts_o)) begin
      id_d  = next_id_i;
      key_d = next_key_i;
    end else if (ctl_i.append && at_fill_i) begin
      id_d = ins_id_i;
    end else if (ctl_i.insert && (here_valid_i || at_fill_i) && !go_after_o) begin
      if (prev_go_after_i) begin
        id_d  = ins_id_i;
        key_d = ctl_i.ins_key;
      end else begin
        id_d  = prev_id_i;
        key_d = prev_key_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    key_q <= key_d;
  end
endmodule

// ===== hw/rtl/tds_chain.sv =====
`timescale 1ns / 1ps
// row of cells forming an ordered list with fill count
module tds_chain #(
  parameter int N   = 8,
  parameter int IdW = 3,
  parameter int CntW = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tds_pkg::chain_ctl_t  ctl_i,
  input  logic [IdW-1:0]       ins_id_i,
  input  logic [IdW-1:0]       rm_id_i,
  output logic [IdW-1:0]       head_id_o,
  output logic [31:0]          head_key_o,
  output logic [CntW-1:0]      fill_o
);
  logic [CntW-1:0] fill_q, fill_d;
  logic [IdW-1:0]  id   [N+1];
  logic [31:0]     key  [N+1];
  logic            ga   [N+1];
  logic            sh   [N+1];
  logic            mt   [N];
  logic            any_match;

  assign id[N]  = '0;
  assign key[N] = '0;
  assign ga[N]  = 1'b0;
  assign sh[N]  = 1'b0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [IdW-1:0] pid;
    logic [31:0]    pkey;
    logic           pga, psh;
    if (g == 0) begin : g_first
      assign pid = '0; assign pkey = '0; assign pga = 1'b1; assign psh = 1'b0;
    end else begin : g_rest
      assign pid = id[g-1]; assign pkey = key[g-1]; assign pga = ga[g-1];
      assign psh = sh[g-1];
    end
    tds_cell #(.IdW(IdW)) u_cell (
      .clk_i, .ctl_i, .ins_id_i,
      .here_valid_i (CntW'(g) < fill_q),
      .at_fill_i    (CntW'(g) == fill_q),
      .id_o (id[g]), .key_o (key[g]), .go_after_o (ga[g]), .match_o (mt[g]),
      .rm_id_i,
      .prev_id_i (pid), .prev_key_i (pkey), .prev_go_after_i (pga),
      .prev_shifts_i (psh),
      .next_id_i (id[g+1]), .next_key_i (key[g+1]),
      .shifts_o (sh[g])
    );
  end

  always_comb begin
    any_match = 1'b0;
    for (int i = 0; i < N; i++) any_match = any_match | mt[i];
  end

  always_comb begin
    fill_d = fill_q;
    if (ctl_i.shift_out && fill_q != '0) fill_d = fill_q - 1'b1;
    else if (ctl_i.remove && any_match) fill_d = fill_q - 1'b1;
    else if ((ctl_i.insert || ctl_i.append) && fill_q < CntW'(N)) fill_d = fill_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fill_q <= '0;
    else fill_q <= fill_d;
  end

  assign head_id_o  = id[0];
  assign head_key_o = key[0];
  assign fill_o     = fill_q;
endmodule

// ===== hw/rtl/tick_delay_task_scheduler.sv =====
`timescale 1ns / 1ps
// flow: schedule, make-ready and delay of a task not yet delayed go from idle straight to ST_OUT;
// delaying a task already delayed passes through ST_REINS (remove, then sorted insert)
// a tick stays in ST_TICK while tasks wake, one head entry released per cycle, then goes to ST_OUT
// throughput: one transaction in flight; next accepted the cycle after the result is taken
// reset: tick count zero, both lists empty, all tasks in no list, idle task current
module tick_delay_task_scheduler (
  input logic         clk_i,
  input logic         rst_ni,
  tds_in_if.sink      in_if,
  tds_out_if.source   out_if
);
  localparam int IdW  = $clog2(tds_pkg::TASK_COUNT);
  localparam int CntW = $clog2(tds_pkg::TASK_COUNT + 1);

  tds_pkg::state_e   state_q, state_d;
  logic [31:0]       tick_q, tick_d;
  tds_pkg::where_e   where_q [tds_pkg::TASK_COUNT];
  logic              run_idle_q, run_idle_d;
  logic [IdW-1:0]    run_q, run_d;
  logic              sw_q, sw_d;
  logic              moved_q, moved_d;
  logic [IdW-1:0]    park_id_q, park_id_d;
  logic [31:0]       park_key_q, park_key_d;

  tds_pkg::chain_ctl_t dctl, rctl;
  logic [IdW-1:0]    d_ins, r_ins, rm_id;
  logic [IdW-1:0]    d_head, r_head;
  logic [31:0]       d_key, r_key_unused;
  logic [CntW-1:0]   d_fill, r_fill;
  logic              acc, tid_ok, wake;
  logic [2:0]        tid;

  assign tid    = in_if.task_id;
  assign tid_ok = 32'(tid) < 32'(tds_pkg::TASK_COUNT);
  assign acc    = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == tds_pkg::ST_IDLE);
  assign wake   = (d_fill != '0) && (d_key < tick_q);

  tds_chain #(.N(tds_pkg::TASK_COUNT), .IdW(IdW), .CntW(CntW)) u_delayed (
    .clk_i, .rst_ni, .ctl_i (dctl), .ins_id_i (d_ins), .rm_id_i (rm_id),
    .head_id_o (d_head), .head_key_o (d_key), .fill_o (d_fill));
  tds_chain #(.N(tds_pkg::TASK_COUNT), .IdW(IdW), .CntW(CntW)) u_ready (
    .clk_i, .rst_ni, .ctl_i (rctl), .ins_id_i (r_ins), .rm_id_i (rm_id),
    .head_id_o (r_head), .head_key_o (r_key_unused), .fill_o (r_fill));

  always_comb begin
    state_d    = state_q;
    tick_d     = tick_q;
    run_d      = run_q;
    run_idle_d = run_idle_q;
    sw_d       = sw_q;
    moved_d    = moved_q;
    park_id_d  = park_id_q;
    park_key_d = park_key_q;
    dctl       = '0;
    rctl       = '0;
    d_ins      = tid[IdW-1:0];
    r_ins      = tid[IdW-1:0];
    rm_id      = tid[IdW-1:0];
    dctl.ins_key = tick_q + in_if.delay_ticks;
    unique case (state_q)
      tds_pkg::ST_IDLE: begin
        if (acc) begin
          sw_d    = 1'b0;
          state_d = tds_pkg::ST_OUT;
          case (tds_pkg::cmd_e'(in_if.cmd))
            tds_pkg::CMD_TICK: begin
              tick_d  = tick_q + 1'b1;
              moved_d = 1'b0;
              state_d = tds_pkg::ST_TICK;
            end
            tds_pkg::CMD_DELAY: begin
              // re-insert of a delayed task is split: remove now, insert next cycle
              if (tid_ok) begin
                if (where_q[tid[IdW-1:0]] == tds_pkg::WHERE_DELAYED) begin
                  dctl.remove = 1'b1;
                  park_id_d   = tid[IdW-1:0];
                  park_key_d  = dctl.ins_key;
                  state_d     = tds_pkg::ST_REINS;
                end else begin
                  rctl.remove = (where_q[tid[IdW-1:0]] == tds_pkg::WHERE_READY);
                  dctl.insert = 1'b1;
                end
              end
            end
            tds_pkg::CMD_SCHED: begin
              if (r_fill != '0) begin
                rctl.shift_out = 1'b1;
                run_d      = r_head;
                run_idle_d = 1'b0;
              end else begin
                run_idle_d = 1'b1;
              end
            end
            default: begin
              if (tid_ok && where_q[tid[IdW-1:0]] == tds_pkg::WHERE_NONE) rctl.append = 1'b1;
            end
          endcase
        end
      end
      tds_pkg::ST_REINS: begin
        dctl.insert  = 1'b1;
        dctl.ins_key = park_key_q;
        d_ins        = park_id_q;
        state_d      = tds_pkg::ST_OUT;
      end
      tds_pkg::ST_TICK: begin
        if (d_fill == '0 && !moved_q) begin
          sw_d    = (r_fill != '0);
          state_d = tds_pkg::ST_OUT;
        end else if (wake) begin
          dctl.shift_out = 1'b1;
          rctl.append    = 1'b1;
          r_ins          = d_head;
          sw_d           = 1'b1;
          moved_d        = 1'b1;
        end else begin
          state_d = tds_pkg::ST_OUT;
        end
      end
      tds_pkg::ST_OUT: begin
        if (out_if.ready) state_d = tds_pkg::ST_IDLE;
      end
      default: state_d = tds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tds_pkg::ST_IDLE;
      tick_q     <= '0;
      run_idle_q <= 1'b1;
      run_q      <= '0;
      sw_q       <= 1'b0;
      moved_q    <= 1'b0;
      park_id_q  <= '0;
      park_key_q <= '0;
      for (int i = 0; i < tds_pkg::TASK_COUNT; i++) where_q[i] <= tds_pkg::WHERE_NONE;
    end else begin
      state_q    <= state_d;
      tick_q     <= tick_d;
      run_q      <= run_d;
      run_idle_q <= run_idle_d;
      sw_q       <= sw_d;
      moved_q    <= moved_d;
      park_id_q  <= park_id_d;
      park_key_q <= park_key_d;
      if (dctl.insert) where_q[d_ins] <= tds_pkg::WHERE_DELAYED;
      if (rctl.append) where_q[r_ins] <= tds_pkg::WHERE_READY;
      if (rctl.shift_out) where_q[r_head] <= tds_pkg::WHERE_NONE;
    end
  end

  assign out_if.valid           = (state_q == tds_pkg::ST_OUT);
  assign out_if.must_switch     = sw_q;
  assign out_if.current_task    = run_idle_q ? 3'd0 : 3'(run_q);
  assign out_if.current_is_idle = run_idle_q;
  assign out_if.ready_count     = 4'(r_fill);
  assign out_if.delayed_count   = 4'(d_fill);

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> state_q == tds_pkg::ST_IDLE) else $error("ready outside idle");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(d_fill) <= 32'(tds_pkg::TASK_COUNT)) && (32'(r_fill) <= 32'(tds_pkg::TASK_COUNT)))
    else $error("fill overflow");
  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_if.cmd == tds_pkg::CMD_TICK) |=> tick_q == $past(tick_q) + 32'd1)
    else $error("tick step");
endmodule
